### rtl/dcf_pkg.sv
package dcf_pkg;

  // Width of the number being factored
  localparam int VALUE_BITS = 16;
  // Candidate divisor never exceeds sqrt(2^VALUE_BITS), plus room for the final step
  localparam int CAND_BITS = VALUE_BITS / 2 + 1;
  // An exponent never exceeds VALUE_BITS - 1; exponent + 1 must also fit
  localparam int EXP_BITS = $clog2(VALUE_BITS + 1);
  localparam int COUNT_BITS = 8;
  localparam int DIV_CNT_BITS = $clog2(VALUE_BITS);

  localparam logic [VALUE_BITS-1:0] MAX_VALUE_RESET = VALUE_BITS'(2000);
  localparam logic [VALUE_BITS-1:0] MIN_VALID = VALUE_BITS'(2);
  localparam logic [CAND_BITS-1:0] FIRST_CAND = CAND_BITS'(2);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Controller states, one-hot
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_RANGE  = 8'b0000_0010,
    S_TEST   = 8'b0000_0100,
    S_DSTART = 8'b0000_1000,
    S_DIV    = 8'b0001_0000,
    S_MULT   = 8'b0010_0000,
    S_FINAL  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // capture a new word, reset the factoring state
    logic div_start;   // divide the remaining value by the candidate
    logic div_accept;  // take the quotient, bump the exponent
    logic mult;        // fold exponent into count, move to next candidate
    logic final_mul;   // double the count for a prime cofactor
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic invalid;     // word out of range
    logic cand_ok;     // cand * cand <= remaining value
    logic div_done;    // divider result ready this cycle
    logic div_zero;    // remainder of the last division is zero
  } stat_t;

endpackage

### rtl/dcf_div.sv
module dcf_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [dcf_pkg::VALUE_BITS-1:0] dividend,
  input  logic [dcf_pkg::CAND_BITS-1:0]  divisor,
  output logic                           done,
  output logic [dcf_pkg::VALUE_BITS-1:0] quotient,
  output logic [dcf_pkg::CAND_BITS-1:0]  remainder
);

  localparam int VB = dcf_pkg::VALUE_BITS;
  localparam int CB = dcf_pkg::CAND_BITS;
  localparam int NB = dcf_pkg::DIV_CNT_BITS;
  localparam logic [NB-1:0] CNT_LAST = NB'(VB - 1);

  logic          run_r;
  logic          done_r;
  logic [NB-1:0] cnt_r;
  logic [VB-1:0] quo_r;
  logic [VB-1:0] quo_nxt;
  logic [CB-1:0] rem_r;
  logic [CB-1:0] rem_nxt;
  logic [CB:0]   shifted;
  logic [CB+1:0] diff;
  logic          ge;

  // Restoring step: shift in one dividend bit, subtract if it fits
  assign shifted = {rem_r, quo_r[VB-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor};
  assign ge      = ~diff[CB+1];
  assign rem_nxt = ge ? diff[CB-1:0] : shifted[CB-1:0];
  assign quo_nxt = {quo_r[VB-2:0], ge};

  // Control: run for one cycle per dividend bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + NB'(1);
        if (cnt_r == CNT_LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (run_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### rtl/dcf_datapath.sv
module dcf_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [dcf_pkg::VALUE_BITS-1:0]  cfg_wr_data,
  input  logic [dcf_pkg::VALUE_BITS-1:0]  number_in,
  input  dcf_pkg::cmd_t                   cmd,
  output dcf_pkg::stat_t                  stat,
  output logic                            status,
  output logic [dcf_pkg::COUNT_BITS-1:0]  divisor_count
);

  localparam int VB = dcf_pkg::VALUE_BITS;
  localparam int CB = dcf_pkg::CAND_BITS;
  localparam int EB = dcf_pkg::EXP_BITS;
  localparam int KB = dcf_pkg::COUNT_BITS;

  logic [VB-1:0]    max_r;
  logic [VB-1:0]    rest_r;
  logic [CB-1:0]    cand_r;
  logic [EB-1:0]    exp_r;
  logic [KB-1:0]    count_r;
  logic             invalid_r;
  logic [2*CB-1:0]  cand_sq;
  logic [EB-1:0]    mul_b;
  logic [KB+EB-1:0] prod;
  logic [KB-1:0]    count_sat;
  logic             div_done;
  logic [VB-1:0]    quotient;
  logic [CB-1:0]    remainder;

  dcf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (rest_r),
    .divisor   (cand_r),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // Hold the range limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= dcf_pkg::MAX_VALUE_RESET;
    end else if (cfg_wr_en) begin
      max_r <= cfg_wr_data;
    end
  end

  // Bound test and shared saturating count multiplier
  assign cand_sq   = cand_r * cand_r;
  assign mul_b     = cmd.final_mul ? EB'(2) : exp_r + EB'(1);
  assign prod      = count_r * mul_b;
  assign count_sat = (prod > (KB+EB)'(dcf_pkg::COUNT_MAX)) ? dcf_pkg::COUNT_MAX : prod[KB-1:0];

  // Factoring state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rest_r    <= number_in;
      cand_r    <= dcf_pkg::FIRST_CAND;
      exp_r     <= '0;
      count_r   <= KB'(1);
      invalid_r <= (number_in < dcf_pkg::MIN_VALID) || (number_in > max_r);
    end else if (cmd.div_accept) begin
      rest_r <= quotient;
      exp_r  <= exp_r + EB'(1);
    end else if (cmd.mult) begin
      count_r <= count_sat;
      exp_r   <= '0;
      cand_r  <= cand_r + CB'(1);
    end else if (cmd.final_mul) begin
      if (rest_r > VB'(1)) begin
        count_r <= count_sat;
      end
    end
  end

  assign stat.invalid  = invalid_r;
  assign stat.cand_ok  = cand_sq <= (2*CB)'(rest_r);
  assign stat.div_done = div_done;
  assign stat.div_zero = remainder == '0;

  assign status        = invalid_r;
  assign divisor_count = invalid_r ? '0 : count_r;

endmodule

### rtl/dcf_ctrl.sv
module dcf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  dcf_pkg::stat_t stat,
  output dcf_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           out_valid
);

  dcf_pkg::state_t state_r;
  dcf_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dcf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequence the trial division
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      dcf_pkg::S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = dcf_pkg::S_RANGE;
        end
      end
      dcf_pkg::S_RANGE: begin
        state_nxt = stat.invalid ? dcf_pkg::S_DONE : dcf_pkg::S_TEST;
      end
      dcf_pkg::S_TEST: begin
        state_nxt = stat.cand_ok ? dcf_pkg::S_DSTART : dcf_pkg::S_FINAL;
      end
      dcf_pkg::S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = dcf_pkg::S_DIV;
      end
      dcf_pkg::S_DIV: begin
        if (stat.div_done) begin
          if (stat.div_zero) begin
            cmd.div_accept = 1'b1;
            state_nxt      = dcf_pkg::S_DSTART;
          end else begin
            state_nxt = dcf_pkg::S_MULT;
          end
        end
      end
      dcf_pkg::S_MULT: begin
        cmd.mult  = 1'b1;
        state_nxt = dcf_pkg::S_TEST;
      end
      dcf_pkg::S_FINAL: begin
        cmd.final_mul = 1'b1;
        state_nxt     = dcf_pkg::S_DONE;
      end
      dcf_pkg::S_DONE: begin
        state_nxt = dcf_pkg::S_IDLE;
      end
      default: begin
        state_nxt = dcf_pkg::S_IDLE;
      end
    endcase
  end

  assign busy      = state_r != dcf_pkg::S_IDLE;
  assign out_valid = state_r == dcf_pkg::S_DONE;

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> state_r == dcf_pkg::S_DIV)
    else $error("divider finished outside the divide state");

endmodule

### rtl/divisor_count_by_factoring.sv
// Divisor counter by trial division.
// Input: present a word on in_number_in with start high; it is taken at a
// clock edge where start is high and busy is low. busy stays high until the
// result has been shown.
// Output: one result per word, out_status (1 = out of range) and
// out_divisor_count, held for exactly one cycle with out_valid high. The
// receiver has no way to stall it.
// Timing: an out-of-range word goes from the range check straight to the
// result. A valid word takes, per trial candidate, a bound test, one
// division more than the exponent found and a count update, each division
// running a one-bit-per-cycle restoring divider over the 16-bit remaining
// value; the worst case (a large prime) is 254 candidates. The next word
// is taken the cycle after the result strobe.
// Configuration: cfg_wr_en with cfg_wr_data writes the largest valid input;
// write only while busy is low.
// Reset (synchronous, rst_n low): controller returns to idle and the limit
// returns to 2000.
module divisor_count_by_factoring (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [dcf_pkg::VALUE_BITS-1:0] cfg_wr_data,
  input  logic                           start,
  input  logic [dcf_pkg::VALUE_BITS-1:0] in_number_in,
  output logic                           busy,
  output logic                           out_valid,
  output logic                           out_status,
  output logic [dcf_pkg::COUNT_BITS-1:0] out_divisor_count
);

  dcf_pkg::cmd_t  cmd;
  dcf_pkg::stat_t stat;

  dcf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  dcf_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .number_in     (in_number_in),
    .cmd           (cmd),
    .stat          (stat),
    .status        (out_status),
    .divisor_count (out_divisor_count)
  );

endmodule
